// File: rtl/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Ring geometry, opcodes, memory request and result records.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int CAPACITY = 1024;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int OP_W     = 3;

	localparam int IN_BITS     = OP_W + DATA_W;
	localparam int OUT_BITS    = 3 * DATA_W + CNT_W + 3;
	localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic signed [DATA_W-1:0] data_t;

	localparam idx_t SLOT_LAST = IDX_W'(CAPACITY - 1);
	localparam cnt_t CNT_FULL  = CNT_W'(CAPACITY);

	typedef enum logic [OP_W-1:0] {
		OP_QUERY      = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_PUSH_BACK  = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_POP_BACK   = 3'd4
	} opcode_t;

	typedef struct packed {
		logic        wr_en;
		logic        rd_en;
		idx_t        addr;
		data_t       wdata;
	} mem_req_t;

	typedef struct packed {
		data_t       back_value;
		data_t       front_value;
		logic        is_empty;
		cnt_t        element_count;
		logic        error_flag;
		logic        popped_valid;
		data_t       popped_value;
	} result_t;

	function automatic idx_t slot_before(input idx_t slot);
		return (slot == '0) ? SLOT_LAST : idx_t'(slot - 1'b1);
	endfunction

	function automatic idx_t slot_after(input idx_t slot);
		return (slot == SLOT_LAST) ? '0 : idx_t'(slot + 1'b1);
	endfunction

endpackage

// File: rtl/dq_ring_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ring_ram: single-port ring storage
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module dq_ring_ram #(
	parameter int DEPTH  = 1024,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (rd_en) begin
			rdata <= mem[addr];
		end
	end

endmodule

// File: rtl/dq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl: pointer, count and end-value control of the deque
// Keeps front/back values cached; a pop that leaves two or more elements refills the cache from the ring.
// ----------------------------------------------------------------------------
module dq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        in_opcode,
	input  dq_pkg::data_t     in_value,
	input  logic              out_free,
	output logic              res_valid,
	output dq_pkg::result_t   res,
	output dq_pkg::mem_req_t  mem_req,
	input  dq_pkg::data_t     mem_rdata
);

	typedef enum logic {ST_IDLE, ST_READ} state_t;

	state_t         state_q;
	dq_pkg::idx_t   front_q, front_d;
	dq_pkg::idx_t   back_q, back_d;
	dq_pkg::cnt_t   cnt_q, cnt_d;
	dq_pkg::data_t  fval_q, fval_d;
	dq_pkg::data_t  bval_q, bval_d;
	dq_pkg::data_t  popped_q, popped_d;
	logic           pvalid_q, pvalid_d;
	logic           err_q, err_d;
	logic           fill_front_q, fill_front_d;
	logic           need_rd;
	logic           in_fire;
	logic           full, empty;
	dq_pkg::idx_t   new_back;

	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign in_fire  = in_valid && in_ready;
	assign full     = (cnt_q == dq_pkg::CNT_FULL);
	assign empty    = (cnt_q == '0);
	assign new_back = dq_pkg::slot_before(back_q);

	always_comb begin
		front_d      = front_q;
		back_d       = back_q;
		cnt_d        = cnt_q;
		fval_d       = fval_q;
		bval_d       = bval_q;
		popped_d     = popped_q;
		pvalid_d     = pvalid_q;
		err_d        = err_q;
		fill_front_d = fill_front_q;
		need_rd      = 1'b0;
		mem_req      = '0;

		if (state_q == ST_IDLE) begin
			if (in_fire) begin
				popped_d = '0;
				pvalid_d = 1'b0;
				err_d    = 1'b0;
				unique case (dq_pkg::opcode_t'(in_opcode))
					dq_pkg::OP_PUSH_FRONT: begin
						if (full) begin
							err_d = 1'b1;
						end else begin
							front_d       = dq_pkg::slot_before(front_q);
							mem_req.wr_en = 1'b1;
							mem_req.addr  = front_d;
							mem_req.wdata = in_value;
							fval_d        = in_value;
							if (empty) begin
								bval_d = in_value;
							end
							cnt_d = cnt_q + 1'b1;
						end
					end
					dq_pkg::OP_PUSH_BACK: begin
						if (full) begin
							err_d = 1'b1;
						end else begin
							mem_req.wr_en = 1'b1;
							mem_req.addr  = back_q;
							mem_req.wdata = in_value;
							back_d        = dq_pkg::slot_after(back_q);
							bval_d        = in_value;
							if (empty) begin
								fval_d = in_value;
							end
							cnt_d = cnt_q + 1'b1;
						end
					end
					dq_pkg::OP_POP_FRONT: begin
						if (empty) begin
							err_d = 1'b1;
						end else begin
							popped_d = fval_q;
							pvalid_d = 1'b1;
							front_d  = dq_pkg::slot_after(front_q);
							cnt_d    = cnt_q - 1'b1;
							if (cnt_q == dq_pkg::CNT_W'(2)) begin
								fval_d = bval_q;
							end else if (cnt_q > dq_pkg::CNT_W'(2)) begin
								// new front lives only in the ring
								need_rd       = 1'b1;
								fill_front_d  = 1'b1;
								mem_req.rd_en = 1'b1;
								mem_req.addr  = front_d;
							end
						end
					end
					dq_pkg::OP_POP_BACK: begin
						if (empty) begin
							err_d = 1'b1;
						end else begin
							popped_d = bval_q;
							pvalid_d = 1'b1;
							back_d   = new_back;
							cnt_d    = cnt_q - 1'b1;
							if (cnt_q == dq_pkg::CNT_W'(2)) begin
								bval_d = fval_q;
							end else if (cnt_q > dq_pkg::CNT_W'(2)) begin
								need_rd       = 1'b1;
								fill_front_d  = 1'b0;
								mem_req.rd_en = 1'b1;
								mem_req.addr  = dq_pkg::slot_before(new_back);
							end
						end
					end
					default: begin
					end
				endcase
			end
		end else begin
			if (fill_front_q) begin
				fval_d = mem_rdata;
			end else begin
				bval_d = mem_rdata;
			end
		end

		res.popped_value  = popped_d;
		res.popped_valid  = pvalid_d;
		res.error_flag    = err_d;
		res.element_count = cnt_d;
		res.is_empty      = (cnt_d == '0);
		res.front_value   = (cnt_d == '0) ? '0 : fval_d;
		res.back_value    = (cnt_d == '0) ? '0 : bval_d;
		res_valid         = (in_fire && !need_rd) || (state_q == ST_READ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= '0;
			back_q  <= '0;
			cnt_q   <= '0;
		end else begin
			front_q <= front_d;
			back_q  <= back_d;
			cnt_q   <= cnt_d;
			unique case (state_q)
				ST_IDLE: if (in_fire && need_rd) begin
					state_q <= ST_READ;
				end
				ST_READ: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		fval_q       <= fval_d;
		bval_q       <= bval_d;
		popped_q     <= popped_d;
		pvalid_q     <= pvalid_d;
		err_q        <= err_d;
		fill_front_q <= fill_front_d;
	end

endmodule

// File: rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque over a ring memory
// Push/pop at either end, one result per request with count and end values.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   opcode, element_value
// m_axis    out  popped_value, popped_valid, error_flag, element_count,
//                is_empty, front_value, back_value
//
// A request's result is registered at the accepting edge; a pop that leaves
// two or more elements registers its result only after the read state, since
// the new end value is fetched through the ring memory read port.
// The input stalls while a result waits in the output register with m_tready low.
// Reset clears state, pointers, count and output valid only; the ring needs no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [2:0] opcode, [34:3] element_value
	input  logic [dq_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [31:0] popped_value, [32] popped_valid, [33] error_flag,
	// [44:34] element_count, [45] is_empty, [77:46] front_value,
	// [109:78] back_value
	output logic [dq_pkg::M_TDATA_W-1:0] m_tdata
);

	logic              out_free;
	logic              res_valid;
	dq_pkg::result_t   res;
	dq_pkg::mem_req_t  mem_req;
	dq_pkg::data_t     mem_rdata;
	logic              m_tvalid_q;
	logic [dq_pkg::M_TDATA_W-1:0] m_tdata_q;

	assign out_free = !m_tvalid_q || m_tready;

	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_opcode (s_tdata[dq_pkg::OP_W-1:0]),
		.in_value  ($signed(s_tdata[dq_pkg::IN_BITS-1:dq_pkg::OP_W])),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	dq_ring_ram #(
		.DEPTH  (dq_pkg::CAPACITY),
		.WIDTH  (dq_pkg::DATA_W),
		.ADDR_W (dq_pkg::IDX_W)
	) u_ram (
		.clk   (clk),
		.wr_en (mem_req.wr_en),
		.rd_en (mem_req.rd_en),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_tdata_q <= dq_pkg::M_TDATA_W'(res);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
